@@ hw/rtl/ibs_pkg.sv @@
// Shared types and constants for the interleaved binary search block.
package ibs_pkg;

   // Field widths fixed by the item formats.
   localparam int ENTRY_WIDTH = 32;
   localparam int INDEX_WIDTH = 4;
   localparam int USED_WIDTH  = 5;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;
   typedef logic [INDEX_WIDTH-1:0]        index_type;
   typedef logic [USED_WIDTH-1:0]         used_type;

   // Item mode codes.
   typedef enum logic {
      MODE_WRITE  = 1'b0,
      MODE_SEARCH = 1'b1
   } mode_type;

   // Entries in use after reset.
   localparam used_type USED_RESET = 5'd16;

endpackage

@@ hw/rtl/ibs_if.sv @@
// Channel interfaces for the interleaved binary search block.
interface ibs_req_if;
   logic               valid;
   logic               ready;
   ibs_pkg::mode_type  mode;
   ibs_pkg::index_type entry_index;
   ibs_pkg::entry_type entry_value;
   ibs_pkg::entry_type search_key;

   modport source (output valid, mode, entry_index, entry_value, search_key, input ready);
   modport sink   (input valid, mode, entry_index, entry_value, search_key, output ready);
endinterface

interface ibs_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   ibs_pkg::index_type found_index;

   modport source (output valid, found, found_index, input ready);
   modport sink   (input valid, found, found_index, output ready);
endinterface

interface ibs_csr_if;
   logic              valid;
   logic              ready;
   ibs_pkg::used_type entries_used;

   modport source (output valid, entries_used, input ready);
   modport sink   (input valid, entries_used, output ready);
endinterface

@@ hw/rtl/ibs_table.sv @@
// Entry table: one write port and one read port with registered read data.
module ibs_table #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  ibs_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output ibs_pkg::entry_type rd_data
);

   ibs_pkg::entry_type mem_ff [DEPTH];
   ibs_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/interleaved_binary_search.sv @@
// Top level of the interleaved binary search block.
//
//   channel  dir  payload                                        role
//   req      in   mode, entry_index, entry_value, search_key     write or search item
//   rsp      out  found, found_index                             one per search item
//   csr      in   entries_used                                   entries in use
//
// A write item goes straight to the table. A search item steps through PROBE
// and COMPARE for each table probe, one PROBE step for each list that runs out,
// and FINISH; no new item is taken until the search is done. The single
// table read port, one probe in flight at a time, sets this pace.
// Reset is synchronous and clears control state only; the table holds
// garbage until written. A result waits in the output register while a new
// item is taken; a finished search holds until that register is free.
module interleaved_binary_search #(
   parameter int TABLE_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   ibs_req_if.sink    req,
   ibs_rsp_if.source  rsp,
   ibs_csr_if.sink    csr
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = AW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   ibs_pkg::used_type      used_ff, used_in;
   logic signed [CW-1:0]   lo_ff, lo_in;
   logic signed [CW-1:0]   hi_ff, hi_in;
   logic signed [CW-1:0]   odd_last_ff, odd_last_in;
   logic [CW-1:0]          mid_ff, mid_in;
   logic                   list_ff, list_in;
   ibs_pkg::entry_type     key_ff, key_in;
   logic                   res_found_ff, res_found_in;
   ibs_pkg::index_type     res_index_ff, res_index_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   ibs_pkg::index_type     rsp_found_index_ff, rsp_found_index_in;

   logic                   req_xfer;
   logic [31:0]            used_ext;
   logic [31:0]            n_w;
   logic [31:0]            even_last_w;
   logic [31:0]            odd_last_w;
   logic [CW-1:0]          diff_w;
   logic [CW-1:0]          mid_w;
   logic [31:0]            probe_pos_w;
   logic [31:0]            hit_pos_w;
   logic                   tbl_wr_en;
   logic [AW-1:0]          tbl_wr_addr;
   logic                   tbl_rd_en;
   logic [AW-1:0]          tbl_rd_addr;
   ibs_pkg::entry_type     tbl_rd_data;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // A write transfer goes straight to the table; positions past the depth are dropped.
   assign tbl_wr_en   = req_xfer && (req.mode == ibs_pkg::MODE_WRITE)
                        && (32'(req.entry_index) < TABLE_DEPTH);
   assign tbl_wr_addr = AW'(req.entry_index);

   // Entries in use, clipped to the depth, and the last index of each list.
   always_comb begin
      used_ext    = 32'(used_ff);
      n_w         = (used_ext > TABLE_DEPTH) ? TABLE_DEPTH : used_ext;
      even_last_w = ((n_w + 32'd1) >> 1) - 32'd1;
      odd_last_w  = (n_w >> 1) - 32'd1;
   end

   // Probe position: middle of the remaining range, rounded down.
   always_comb begin
      diff_w      = $unsigned(hi_ff) - $unsigned(lo_ff);
      mid_w       = $unsigned(lo_ff) + (diff_w >> 1);
      probe_pos_w = (32'(mid_w) << 1) | 32'(list_ff);
      hit_pos_w   = (32'(mid_ff) << 1) | 32'(list_ff);
   end

   assign tbl_rd_addr = probe_pos_w[AW-1:0];

   // Search sequencer. Reads never share a cycle with writes, which come only in idle.
   always_comb begin
      state_in           = state_ff;
      used_in            = used_ff;
      lo_in              = lo_ff;
      hi_in              = hi_ff;
      odd_last_in        = odd_last_ff;
      mid_in             = mid_ff;
      list_in            = list_ff;
      key_in             = key_ff;
      res_found_in       = res_found_ff;
      res_index_in       = res_index_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_found_index_in = rsp_found_index_ff;
      tbl_rd_en          = 1'b0;

      if (csr.valid && csr.ready) begin
         used_in = csr.entries_used;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req.mode == ibs_pkg::MODE_SEARCH)) begin
               key_in      = req.search_key;
               lo_in       = '0;
               hi_in       = even_last_w[CW-1:0];
               odd_last_in = odd_last_w[CW-1:0];
               list_in     = 1'b0;
               state_in    = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff > hi_ff) begin
               if (!list_ff) begin
                  // Even list missed; go on with the odd list.
                  list_in = 1'b1;
                  lo_in   = '0;
                  hi_in   = odd_last_ff;
               end else begin
                  res_found_in = 1'b0;
                  res_index_in = '0;
                  state_in     = ST_FINISH;
               end
            end else begin
               mid_in    = mid_w;
               tbl_rd_en = 1'b1;
               state_in  = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (tbl_rd_data == key_ff) begin
               res_found_in = 1'b1;
               res_index_in = hit_pos_w[ibs_pkg::INDEX_WIDTH-1:0];
               state_in     = ST_FINISH;
            end else if (tbl_rd_data < key_ff) begin
               lo_in    = $signed(mid_ff + CW'(1));
               state_in = ST_PROBE;
            end else begin
               hi_in    = $signed(mid_ff - CW'(1));
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = res_found_ff;
               rsp_found_index_in = res_index_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= ibs_pkg::USED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff              <= lo_in;
      hi_ff              <= hi_in;
      odd_last_ff        <= odd_last_in;
      mid_ff             <= mid_in;
      list_ff            <= list_in;
      key_ff             <= key_in;
      res_found_ff       <= res_found_in;
      res_index_ff       <= res_index_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_found_index_ff <= rsp_found_index_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.found_index = rsp_found_index_ff;

   // Entry table.
   ibs_table #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req.entry_value),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

`ifndef SYNTHESIS
   // A new result only appears after a search has finished.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised without a finished search");

   // Compare always sees data read in the cycle before.
   a_compare_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> $past(tbl_rd_en))
      else $error("compare without a table read");

   // A miss always reports index zero.
   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_found_index_ff == '0))
      else $error("miss with a nonzero index");

   // The lower bound of a search never goes negative.
   a_lo_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff >= 0))
      else $error("negative lower bound");
`endif

endmodule
